// ===== src/rcc_pkg.sv =====
// shared types, constants and the detector angle table for the ring centroid block
package rcc_pkg;

    localparam int CHANNELS = 16;
    localparam int CHAN_W   = 4;
    localparam int CHARGE_W = 16;
    localparam int SUM_W    = 20;
    localparam int WSUM_W   = 36;
    localparam int PROD_W   = 33;
    localparam int RADIUS_W = 15;
    localparam int POS_W    = 16;
    localparam int QUOT_W   = 17;
    localparam int ALU_W    = 53;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
    localparam logic [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd12288;

    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

    typedef logic signed [15:0] trig_t;

    // q1.15 cosine and sine of k * 2pi / 16
    localparam trig_t COS_TAB [CHANNELS] = '{
        16'sd32767,  16'sd30274,  16'sd23170,  16'sd12540,
        16'sd0,      -16'sd12540, -16'sd23170, -16'sd30274,
        -16'sd32767, -16'sd30274, -16'sd23170, -16'sd12540,
        16'sd0,      16'sd12540,  16'sd23170,  16'sd30274
    };

    localparam trig_t SIN_TAB [CHANNELS] = '{
        16'sd0,      16'sd12540,  16'sd23170,  16'sd30274,
        16'sd32767,  16'sd30274,  16'sd23170,  16'sd12540,
        16'sd0,      -16'sd12540, -16'sd23170, -16'sd30274,
        -16'sd32767, -16'sd30274, -16'sd23170, -16'sd12540
    };

endpackage

// ===== src/rcc_alu.sv =====
// shared add/subtract unit used for accumulation, multiply and divide steps
module rcc_alu
    import rcc_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    input  alu_op_t          op,
    output logic [ALU_W:0]   res
);

    logic [ALU_W:0] a_ext;
    logic [ALU_W:0] b_ext;

    assign a_ext = {a[ALU_W-1], a};
    assign b_ext = {b[ALU_W-1], b};

    always_comb
    begin
        case (op)
            ALU_SUB: res = a_ext - b_ext;
            default: res = a_ext + b_ext;
        endcase
    end

endmodule

// ===== src/ring_charge_centroid.sv =====
// ring centroid: item accumulate, then shift-add multiply and restoring divide per axis
// a non-final item steps through accept, product, x add and y add
// a final item with nonzero total then scales and divides both axes in turn through
// the one shared adder (set, multiply, overflow check, divide, finish), then loads the result
// a zero total skips the division; the result register frees the input side
// reset clears sums, the sequencer and the result valid; ring_radius resets to 3.0 cm
module ring_charge_centroid
    import rcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHARGE_W-1:0]  charge,
    input  logic [CHAN_W-1:0]    channel,
    input  logic                 last_of_event,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     pos_x,
    output logic [POS_W-1:0]     pos_y,
    output logic [SUM_W-1:0]     event_total,
    output logic                 zero_charge,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RADIUS_W-1:0]  cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MX   = 4'd1;
    localparam logic [3:0] S_AX   = 4'd2;
    localparam logic [3:0] S_AY   = 4'd3;
    localparam logic [3:0] S_MSET = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_OVF  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    localparam logic [4:0] MUL_LAST = 5'(RADIUS_W - 1);
    localparam logic [4:0] DIV_TOP  = 5'(QUOT_W - 1);

    logic [3:0]            state_reg, state_next;
    logic [RADIUS_W-1:0]   radius_reg, radius_next;
    logic [SUM_W-1:0]      charge_sum_reg, charge_sum_next;
    logic [WSUM_W-1:0]     wx_reg, wx_next;
    logic [WSUM_W-1:0]     wy_reg, wy_next;
    logic [CHARGE_W-1:0]   charge_reg, charge_next;
    trig_t                 cos_reg, cos_next;
    trig_t                 sin_reg, sin_next;
    logic                  last_reg, last_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  axis_reg, axis_next;
    logic                  neg_reg, neg_next;
    logic [WSUM_W-1:0]     mag_reg, mag_next;
    logic [ALU_W-1:0]      acc_reg, acc_next;
    logic [ALU_W-1:0]      div_reg, div_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic                  big_reg, big_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [POS_W-1:0]      px_reg, px_next;
    logic [POS_W-1:0]      py_reg, py_next;
    logic                  zero_reg, zero_next;
    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      out_x_reg, out_x_next;
    logic [POS_W-1:0]      out_y_reg, out_y_next;
    logic [SUM_W-1:0]      out_total_reg, out_total_next;
    logic                  out_zero_reg, out_zero_next;

    logic [ALU_W-1:0]      alu_a, alu_b;
    alu_op_t               alu_op;
    logic [ALU_W:0]        alu_res;
    logic [WSUM_W-1:0]     wsum_sat;
    logic                  ovf_pos, ovf_neg;
    logic signed [PROD_W-1:0] mul_res;
    trig_t                 trig_sel;
    logic [SUM_W:0]        sum_wide;
    logic                  chan_ok;
    logic [WSUM_W-1:0]     w_sel;
    logic [QUOT_W-1:0]     quot_neg;
    logic [POS_W-1:0]      pos_val;
    logic                  emit_go;
    logic                  in_fire;

    rcc_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .op  (alu_op),
        .res (alu_res)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    // radius only changes between items so a running division keeps its scale
    assign cfg_ready    = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign pos_x        = out_x_reg;
    assign pos_y        = out_y_reg;
    assign event_total  = out_total_reg;
    assign zero_charge  = out_zero_reg;

    assign chan_ok  = ({1'b0, channel} < 5'(CHANNELS));
    assign sum_wide = {1'b0, charge_sum_reg} + {{(SUM_W + 1 - CHARGE_W){1'b0}}, charge};
    assign trig_sel = (state_reg == S_MX) ? cos_reg : sin_reg;
    assign mul_res  = $signed({1'b0, charge_reg}) * trig_sel;
    assign w_sel    = axis_reg ? wy_reg : wx_reg;
    assign quot_neg = ~quot_reg + {{(QUOT_W-1){1'b0}}, 1'b1};
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    // saturate the accumulator sum back to the weighted-sum range
    assign ovf_pos  = !alu_res[ALU_W] && (alu_res[ALU_W-1:WSUM_W-1] != '0);
    assign ovf_neg  = alu_res[ALU_W] && (alu_res[ALU_W-1:WSUM_W-1] != '1);
    assign wsum_sat = ovf_pos ? WSUM_MAX : (ovf_neg ? WSUM_MIN : alu_res[WSUM_W-1:0]);

    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        case (state_reg)
            S_AX:
            begin
                alu_a = {{(ALU_W-WSUM_W){wx_reg[WSUM_W-1]}}, wx_reg};
                alu_b = {{(ALU_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            S_AY:
            begin
                alu_a = {{(ALU_W-WSUM_W){wy_reg[WSUM_W-1]}}, wy_reg};
                alu_b = {{(ALU_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
            S_MUL:
            begin
                alu_a = acc_reg;
                if (radius_reg[cnt_reg[3:0]])
                begin
                    alu_b = {{(ALU_W-WSUM_W){1'b0}}, mag_reg} << cnt_reg[3:0];
                end
            end
            S_OVF:
            begin
                // numerator against divisor times 2^17
                alu_a  = acc_reg;
                alu_b  = {1'b0, charge_sum_reg, 32'd0};
                alu_op = ALU_SUB;
            end
            S_DIV:
            begin
                alu_a  = acc_reg;
                alu_b  = div_reg;
                alu_op = ALU_SUB;
            end
            default:
            begin
                alu_a  = '0;
                alu_b  = '0;
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        if (big_reg)
        begin
            pos_val = neg_reg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (neg_reg)
        begin
            pos_val = (quot_reg > 17'd32768) ? {1'b1, {(POS_W-1){1'b0}}}
                                             : quot_neg[POS_W-1:0];
        end
        else
        begin
            pos_val = (quot_reg > 17'd32767) ? {1'b0, {(POS_W-1){1'b1}}}
                                             : quot_reg[POS_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        radius_next     = radius_reg;
        charge_sum_next = charge_sum_reg;
        wx_next         = wx_reg;
        wy_next         = wy_reg;
        charge_next     = charge_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        axis_next       = axis_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        acc_next        = acc_reg;
        div_next        = div_reg;
        quot_next       = quot_reg;
        big_next        = big_reg;
        cnt_next        = cnt_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        zero_next       = zero_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_total_next  = out_total_reg;
        out_zero_next   = out_zero_reg;

        if (cfg_valid && cfg_ready)
        begin
            radius_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    charge_next = charge;
                    last_next   = last_of_event;
                    // out-of-range channel adds nothing
                    if (chan_ok)
                    begin
                        cos_next        = COS_TAB[channel];
                        sin_next        = SIN_TAB[channel];
                        charge_sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    end
                    else
                    begin
                        cos_next = '0;
                        sin_next = '0;
                    end
                    state_next = S_MX;
                end
            end
            S_MX:
            begin
                prod_next  = PROD_W'(mul_res);
                state_next = S_AX;
            end
            S_AX:
            begin
                wx_next    = wsum_sat;
                prod_next  = PROD_W'(mul_res);
                state_next = S_AY;
            end
            S_AY:
            begin
                wy_next = wsum_sat;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (charge_sum_reg == '0)
                begin
                    px_next    = '0;
                    py_next    = '0;
                    zero_next  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    axis_next  = 1'b0;
                    zero_next  = 1'b0;
                    state_next = S_MSET;
                end
            end
            S_MSET:
            begin
                neg_next   = w_sel[WSUM_W-1];
                mag_next   = w_sel[WSUM_W-1] ? (~w_sel + {{(WSUM_W-1){1'b0}}, 1'b1}) : w_sel;
                // rounding term: half the divisor
                acc_next   = {{(ALU_W-SUM_W-14){1'b0}}, charge_sum_reg, 14'd0};
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next = alu_res[ALU_W-1:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_OVF;
                end
            end
            S_OVF:
            begin
                big_next   = !alu_res[ALU_W];
                div_next   = {2'b00, charge_sum_reg, 31'd0};
                quot_next  = '0;
                cnt_next   = DIV_TOP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!alu_res[ALU_W])
                begin
                    acc_next = alu_res[ALU_W-1:0];
                end
                quot_next = {quot_reg[QUOT_W-2:0], !alu_res[ALU_W]};
                div_next  = div_reg >> 1;
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (axis_reg)
                begin
                    py_next    = pos_val;
                    state_next = S_EMIT;
                end
                else
                begin
                    px_next    = pos_val;
                    axis_next  = 1'b1;
                    state_next = S_MSET;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = px_reg;
                    out_y_next      = py_reg;
                    out_total_next  = charge_sum_reg;
                    out_zero_next   = zero_reg;
                    charge_sum_next = '0;
                    wx_next         = '0;
                    wy_next         = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            radius_reg     <= RADIUS_RESET;
            charge_sum_reg <= '0;
            wx_reg         <= '0;
            wy_reg         <= '0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            axis_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            radius_reg     <= radius_next;
            charge_sum_reg <= charge_sum_next;
            wx_reg         <= wx_next;
            wy_reg         <= wy_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            axis_reg       <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        charge_reg    <= charge_next;
        cos_reg       <= cos_next;
        sin_reg       <= sin_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        acc_reg       <= acc_next;
        div_reg       <= div_next;
        quot_reg      <= quot_next;
        big_reg       <= big_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        zero_reg      <= zero_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_total_reg <= out_total_next;
        out_zero_reg  <= out_zero_next;
    end

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_zero_reg |->
            out_x_reg == '0 && out_y_reg == '0 && out_total_reg == '0)
        else $error("zero-charge item carries nonzero fields");

    a_nonzero_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_zero_reg |-> out_total_reg != '0)
        else $error("position item with zero total");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> charge_sum_reg == '0 && wx_reg == '0 && wy_reg == '0)
        else $error("sums not cleared after event");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= DIV_TOP)
        else $error("divide step count out of range");

endmodule

// ===== tb/sv/ring_charge_centroid_tb.sv =====
// testbench for the ring centroid block: directed table, random events, scoreboard
module ring_charge_centroid_tb;
    import rcc_pkg::*;

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned RING_N     = CHANNELS;
    localparam int unsigned     CHARGE_CAP = 1048575;
    localparam longint          WEIGHT_MAX = 64'sd34359738367;
    localparam longint          WEIGHT_MIN = -64'sd34359738368;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int SETTLE_CYCLES   = 100;
    localparam int DIR_ROWS        = 24;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [SUM_W-1:0] total;
        logic             zero;
    } centroid_t;

    typedef struct packed {
        logic [CHARGE_W-1:0] charge;
        logic [CHAN_W-1:0]   channel;
        logic                last;
        logic                fixed;
        centroid_t           want;
    } stim_row_t;

    // rows with fixed set carry a result that is obvious by hand
    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        '{16'd0,     4'd0,  1'b1, 1'b1, '{16'd0,     16'd0, 20'd0,     1'b1}},
        '{16'd65535, 4'd0,  1'b1, 1'b1, '{16'd12288, 16'd0, 20'd65535, 1'b0}},
        '{16'd65535, 4'd8,  1'b1, 1'b1, '{16'hD000,  16'd0, 20'd65535, 1'b0}},
        '{16'd1,     4'd4,  1'b0, 1'b0, '0},
        '{16'd1,     4'd12, 1'b1, 1'b1, '{16'd0,     16'd0, 20'd2,     1'b0}},
        '{16'd0,     4'd3,  1'b0, 1'b0, '0},
        '{16'd0,     4'd11, 1'b0, 1'b0, '0},
        '{16'd0,     4'd15, 1'b1, 1'b1, '{16'd0,     16'd0, 20'd0,     1'b1}},
        '{16'd65535, 4'd0,  1'b0, 1'b0, '0},
        '{16'd1,     4'd1,  1'b0, 1'b0, '0},
        '{16'd32768, 4'd2,  1'b0, 1'b0, '0},
        '{16'd12345, 4'd3,  1'b0, 1'b0, '0},
        '{16'd0,     4'd4,  1'b0, 1'b0, '0},
        '{16'd54321, 4'd5,  1'b0, 1'b0, '0},
        '{16'd255,   4'd6,  1'b0, 1'b0, '0},
        '{16'd65280, 4'd7,  1'b0, 1'b0, '0},
        '{16'd4660,  4'd8,  1'b0, 1'b0, '0},
        '{16'd43981, 4'd9,  1'b0, 1'b0, '0},
        '{16'd7,     4'd10, 1'b0, 1'b0, '0},
        '{16'd60000, 4'd11, 1'b0, 1'b0, '0},
        '{16'd1000,  4'd12, 1'b0, 1'b0, '0},
        '{16'd30000, 4'd13, 1'b0, 1'b0, '0},
        '{16'd2,     4'd14, 1'b0, 1'b0, '0},
        '{16'd65535, 4'd15, 1'b1, 1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CHARGE_W-1:0] charge;
    logic [CHAN_W-1:0]   channel;
    logic                last_of_event;
    logic                out_valid;
    logic                out_ready;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [SUM_W-1:0]    event_total;
    logic                zero_charge;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RADIUS_W-1:0] cfg_data;

    // predictor state
    int                  cos_q15 [CHANNELS];
    int                  sin_q15 [CHANNELS];
    logic [RADIUS_W-1:0] radius_now;
    int unsigned         event_charge;
    longint              event_wx;
    longint              event_wy;

    centroid_t   pending_q [$];
    centroid_t   seen;
    centroid_t   owed;
    int unsigned mismatches;
    bit          quiet;

    ring_charge_centroid DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .charge        (charge),
        .channel       (channel),
        .last_of_event (last_of_event),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .event_total   (event_total),
        .zero_charge   (zero_charge),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic longint unsigned q30_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b + (Q30_ONE >> 1)) >> 30;
    endfunction

    function automatic longint unsigned taylor_step(input longint unsigned t2,
                                                    input longint unsigned h,
                                                    input longint unsigned d);
        longint unsigned sub;
        sub = q30_mul(t2, h) / d;
        return (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
    endfunction

    function automatic int q15_of(input longint unsigned v);
        longint unsigned q;
        q = (v + 64'd16384) >> 15;
        return (q > 64'd32767) ? 32767 : int'(q);
    endfunction

    // detector angles: taylor series in q30 within a quadrant, then quadrant swap
    function automatic void build_angles();
        longint unsigned t;
        longint unsigned t2;
        longint unsigned hs;
        longint unsigned hc;
        longint unsigned rem;
        longint unsigned m;
        int quad;
        int c;
        int s;
        for (int k = 0; k < CHANNELS; k++)
        begin
            quad = (4 * k) / CHANNELS;
            rem = 4 * k - quad * CHANNELS;
            t = (rem * HALF_PI_Q30 + RING_N / 2) / RING_N;
            t2 = q30_mul(t, t);
            hs = Q30_ONE;
            hc = Q30_ONE;
            for (int i = 0; i < 6; i++)
            begin
                m = 12 - 2 * i;
                hs = taylor_step(t2, hs, m * (m + 1));
                hc = taylor_step(t2, hc, (m - 1) * m);
            end
            s = q15_of(q30_mul(t, hs));
            c = q15_of(hc);
            case (quad & 3)
                0:       begin cos_q15[k] = c;  sin_q15[k] = s;  end
                1:       begin cos_q15[k] = -s; sin_q15[k] = c;  end
                2:       begin cos_q15[k] = -c; sin_q15[k] = -s; end
                default: begin cos_q15[k] = s;  sin_q15[k] = -c; end
            endcase
        end
    endfunction

    function automatic longint clamp_weight(input longint v);
        if (v > WEIGHT_MAX)
            return WEIGHT_MAX;
        if (v < WEIGHT_MIN)
            return WEIGHT_MIN;
        return v;
    endfunction

    // radius * w / (total * 2^15), ties away from zero, saturated to 16 bits
    function automatic logic [POS_W-1:0] scale_axis(input longint w,
                                                    input longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        if (w < 0)
            mag = -w;
        else
            mag = w;
        quo = (mag * radius_now + (den >> 1)) / den;
        if (w < 0)
            return (quo > 64'd32768) ? 16'h8000 : 16'(64'd0 - quo);
        return (quo > 64'd32767) ? 16'h7FFF : quo[POS_W-1:0];
    endfunction

    // fold one channel into the event sums; returns 1 when the event closes
    function automatic bit fold_channel(input logic [CHARGE_W-1:0] q,
                                        input logic [CHAN_W-1:0] ch,
                                        input logic lst,
                                        output centroid_t res);
        int unsigned sum;
        longint unsigned den;
        res = '0;
        if (ch < CHANNELS)
        begin
            sum = event_charge + q;
            event_charge = (sum > CHARGE_CAP) ? CHARGE_CAP : sum;
            event_wx = clamp_weight(event_wx + longint'({48'd0, q}) * cos_q15[ch]);
            event_wy = clamp_weight(event_wy + longint'({48'd0, q}) * sin_q15[ch]);
        end
        if (!lst)
            return 1'b0;
        if (event_charge == 0)
        begin
            res.zero = 1'b1;
        end
        else
        begin
            den = longint'(event_charge) << 15;
            res.x = scale_axis(event_wx, den);
            res.y = scale_axis(event_wy, den);
            res.total = event_charge[SUM_W-1:0];
        end
        event_charge = 0;
        event_wx = 0;
        event_wy = 0;
        return 1'b1;
    endfunction

    task automatic pause_input(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_item(input logic [CHARGE_W-1:0] q, input logic [CHAN_W-1:0] ch,
                             input logic lst, input bit fixed, input centroid_t want);
        centroid_t res;
        if (!quiet && $urandom_range(0, 4) == 0)
            pause_input($urandom_range(1, 7));
        @(negedge clk);
        in_valid <= 1'b1;
        charge <= q;
        channel <= ch;
        last_of_event <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (fold_channel(q, ch, lst, res))
            pending_q.insert(pending_q.size(), fixed ? want : res);
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] r);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        radius_now = r;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly ordinary events, some all-zero ones, some long single-channel ones
    // that can drive the sums into saturation; each phase opens with such a long one
    task automatic run_events(input int phase);
        int sent;
        int len;
        bit first;
        bit hot;
        bit zero_evt;
        logic [CHAN_W-1:0] ch;
        logic [CHARGE_W-1:0] q;
        sent = 0;
        first = 1'b1;
        while (sent < ITEMS_PER_PHASE)
        begin
            hot = first || ($urandom_range(0, 11) == 0);
            zero_evt = !hot && ($urandom_range(0, 9) == 0);
            len = hot ? $urandom_range(17, 20) : $urandom_range(1, 16);
            ch = first ? CHAN_W'(4 * ((phase + 3) % 4)) : CHAN_W'($urandom_range(0, 15));
            for (int i = 0; i < len; i++)
            begin
                if (first)
                    q = 16'hFFFF;
                else if (hot)
                    q = 16'($urandom_range(60000, 65535));
                else if (zero_evt)
                    q = 16'd0;
                else if ($urandom_range(0, 5) == 0)
                    q = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    q = 16'($urandom);
                if (!hot)
                    ch = CHAN_W'($urandom_range(0, 15));
                send_item(q, ch, i == len - 1, 1'b0, '0);
            end
            sent += len;
            first = 1'b0;
            if (!quiet && $urandom_range(0, 14) == 0)
                wait_all_results();
        end
    endtask

    function automatic logic [RADIUS_W-1:0] radius_for(input int phase);
        case (phase)
            0:       return 15'd0;
            1:       return 15'd32767;
            2:       return 15'($urandom);
            3:       return 15'd1;
            4:       return 15'd20000;
            default: return RADIUS_RESET;
        endcase
    endfunction

    // receiver side: random stall bursts, long runs of ready in between
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    repeat (30) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{pos_x, pos_y, event_total, zero_charge};
            if (pending_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: x=%0d y=%0d total=%0d zero=%0d",
                             $signed(seen.x), $signed(seen.y), seen.total, seen.zero);
                mismatches++;
            end
            else
            begin
                owed = pending_q.pop_front();
                if (seen !== owed)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected x=%0d y=%0d total=%0d zero=%0d, %s",
                                 $signed(owed.x), $signed(owed.y), owed.total, owed.zero,
                                 $sformatf("got x=%0d y=%0d total=%0d zero=%0d",
                                           $signed(seen.x), $signed(seen.y),
                                           seen.total, seen.zero));
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        charge = '0;
        channel = '0;
        last_of_event = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        quiet = 1'b0;
        build_angles();
        radius_now = RADIUS_RESET;
        event_charge = 0;
        event_wx = 0;
        event_wy = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TAB[i].charge, DIR_TAB[i].channel, DIR_TAB[i].last,
                      DIR_TAB[i].fixed, DIR_TAB[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_all_results();
            write_radius(radius_for(p));
            quiet = (p == PHASES - 1);
            run_events(p);
        end
        wait_all_results();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
